@@ rtl/core/mmpa_pkg.sv @@
package mmpa_pkg;

    // table geometry
    localparam int MAX_ENTRIES = 64;
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    // fixed field widths
    localparam int TYPE_W  = 3;
    localparam int ADDR_W  = 64;
    localparam int PC_W    = 21;
    localparam int BS_W    = 13;
    localparam int IDX_W   = 6;
    localparam int OUTA_W  = 32;
    localparam int CNT_W   = 7;
    localparam int XW      = (CW > IDX_W) ? CW : IDX_W;
    localparam int OW      = (CW > CNT_W) ? CW : CNT_W;
    localparam int SIZE_W  = PC_W + 12;
    localparam int BSZ_W   = BS_W + 1;

    localparam logic [TYPE_W-1:0] TYPE_USABLE = '0;
    localparam logic [SIZE_W-1:0] PAGE_SIZE   = SIZE_W'(32'h1000);

    typedef enum logic [2:0] {
        KIND_LOAD  = 3'd0,
        KIND_PAGES = 3'd1,
        KIND_BYTES = 3'd2,
        KIND_CLEAN = 3'd3,
        KIND_READ  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        logic [TYPE_W-1:0] rtype;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] len;
    } entry_t;

    // datapath commands
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOAD,
        OP_RD_REQ,
        OP_RD_DONE,
        OP_RD_BAD,
        OP_PAGES_ZERO,
        OP_SCAN_INIT,
        OP_SCAN_READ,
        OP_CHECK,
        OP_SKIP,
        OP_FIT_WRITE,
        OP_PREV_READ,
        OP_PREV_WRITE,
        OP_PAGE_OK,
        OP_FAIL,
        OP_BYTE_FAST,
        OP_CL_INIT,
        OP_CL_READ,
        OP_CL_WRITE,
        OP_CL_DONE,
        OP_OUT
    } dp_op_t;

    // datapath status back to the controller
    typedef struct packed {
        kind_t kind;
        logic  full;
        logic  idx_ok;
        logic  pages_zero;
        logic  need_page;
        logic  scan_empty;
        logic  fit;
        logic  zero;
        logic  first;
        logic  cl_end;
    } dp_stat_t;

endpackage

@@ rtl/core/mmpa_datapath.sv @@
module mmpa_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mmpa_pkg::dp_op_t                    op,
    input  logic [2:0]                          in_kind,
    input  logic [mmpa_pkg::TYPE_W-1:0]         in_type,
    input  logic [mmpa_pkg::ADDR_W-1:0]         in_base,
    input  logic [mmpa_pkg::ADDR_W-1:0]         in_length,
    input  logic [mmpa_pkg::PC_W-1:0]           in_pages,
    input  logic [mmpa_pkg::BS_W-1:0]           in_bytes,
    input  logic [mmpa_pkg::IDX_W-1:0]          in_index,
    output mmpa_pkg::dp_stat_t                  stat,
    output logic [1:0]                          out_status,
    output logic [mmpa_pkg::OUTA_W-1:0]         out_address,
    output logic [mmpa_pkg::CNT_W-1:0]          out_count,
    output logic [mmpa_pkg::TYPE_W-1:0]         out_type,
    output logic [mmpa_pkg::ADDR_W-1:0]         out_base,
    output logic [mmpa_pkg::ADDR_W-1:0]         out_length
);

    localparam int AW = mmpa_pkg::AW;
    localparam int CW = mmpa_pkg::CW;

    // region table
    mmpa_pkg::entry_t mem [mmpa_pkg::MAX_ENTRIES];
    mmpa_pkg::entry_t rdata_reg;

    // captured request
    mmpa_pkg::kind_t                  kind_reg;
    logic [mmpa_pkg::TYPE_W-1:0]      type_reg;
    logic [mmpa_pkg::ADDR_W-1:0]      base_reg;
    logic [mmpa_pkg::ADDR_W-1:0]      len_reg;
    logic [mmpa_pkg::PC_W-1:0]        pages_reg;
    logic [mmpa_pkg::BSZ_W-1:0]       bsize_reg;
    logic [mmpa_pkg::IDX_W-1:0]       index_reg;

    // control state
    logic [CW-1:0]                    used_reg;
    logic [31:0]                      bump_reg;
    logic [CW-1:0]                    i_reg;
    logic [CW-1:0]                    w_reg;

    // scan state
    logic [mmpa_pkg::SIZE_W-1:0]      size_reg;
    logic                             fit_reg;
    logic                             zero_reg;
    logic [31:0]                      found_reg;

    // staged result
    mmpa_pkg::status_t                res_status_reg;
    logic [31:0]                      res_addr_reg;
    mmpa_pkg::entry_t                 res_entry_reg;

    // output register
    logic [1:0]                       o_status_reg;
    logic [31:0]                      o_addr_reg;
    logic [mmpa_pkg::CNT_W-1:0]       o_count_reg;
    mmpa_pkg::entry_t                 o_entry_reg;

    logic [CW-1:0]                    e_full;
    logic [AW-1:0]                    e_addr;
    logic [AW-1:0]                    prev_addr;
    logic [mmpa_pkg::XW-1:0]          idx_x;
    logic [mmpa_pkg::OW-1:0]          used_o;
    logic [mmpa_pkg::SIZE_W:0]        end_sum;
    logic [mmpa_pkg::SIZE_W-1:0]      delta;
    logic                             fit_c;
    logic [11:0]                      bump_off;
    logic [mmpa_pkg::BSZ_W-1:0]       room;
    logic                             mem_we;
    logic [AW-1:0]                    mem_waddr;
    mmpa_pkg::entry_t                 mem_wdata;
    logic                             mem_re;
    logic [AW-1:0]                    mem_raddr;

    // index arithmetic
    assign e_full    = i_reg - 1'b1;
    assign e_addr    = e_full[AW-1:0];
    assign prev_addr = e_addr - 1'b1;
    assign idx_x     = mmpa_pkg::XW'(index_reg);
    assign used_o    = mmpa_pkg::OW'(used_reg);

    // fit test on the entry just read: usable, below 4 GiB, ends in range, long enough
    assign end_sum = {1'b0, rdata_reg.base[31:0]} + (mmpa_pkg::SIZE_W + 1)'(size_reg);
    assign fit_c   = (rdata_reg.rtype == mmpa_pkg::TYPE_USABLE)
                   && (rdata_reg.base[63:32] == '0)
                   && (end_sum <= (mmpa_pkg::SIZE_W + 1)'(34'h1_0000_0000))
                   && !(rdata_reg.len < mmpa_pkg::ADDR_W'(size_reg));
    assign delta   = zero_reg ? mmpa_pkg::PAGE_SIZE : size_reg;

    // room left in the current bump page
    assign bump_off = bump_reg[11:0];
    assign room     = mmpa_pkg::BSZ_W'(14'h1000) - mmpa_pkg::BSZ_W'(bump_off);

    assign stat.kind       = kind_reg;
    assign stat.full       = (used_reg == CW'(mmpa_pkg::MAX_ENTRIES));
    assign stat.idx_ok     = idx_x < mmpa_pkg::XW'(used_reg);
    assign stat.pages_zero = (pages_reg == '0);
    assign stat.need_page  = (bump_off == '0) || (room < bsize_reg);
    assign stat.scan_empty = (i_reg == '0);
    assign stat.fit        = fit_reg;
    assign stat.zero       = zero_reg;
    assign stat.first      = (e_addr == '0);
    assign stat.cl_end     = (i_reg == used_reg);

    // table port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = e_addr;
        mem_wdata = rdata_reg;
        mem_re    = 1'b0;
        mem_raddr = e_addr;
        case (op)
            mmpa_pkg::OP_LOAD: begin
                mem_we    = !stat.full;
                mem_waddr = used_reg[AW-1:0];
                mem_wdata = '{rtype: type_reg, base: base_reg, len: len_reg};
            end
            mmpa_pkg::OP_FIT_WRITE: begin
                mem_we          = 1'b1;
                mem_wdata.base  = rdata_reg.base + mmpa_pkg::ADDR_W'(delta);
                mem_wdata.len   = rdata_reg.len - mmpa_pkg::ADDR_W'(delta);
            end
            mmpa_pkg::OP_PREV_WRITE: begin
                mem_we        = 1'b1;
                mem_waddr     = prev_addr;
                mem_wdata.len = rdata_reg.len + mmpa_pkg::ADDR_W'(delta);
            end
            mmpa_pkg::OP_CL_WRITE: begin
                mem_we    = (rdata_reg.len != '0);
                mem_waddr = w_reg[AW-1:0];
            end
            mmpa_pkg::OP_RD_REQ: begin
                mem_re    = 1'b1;
                mem_raddr = idx_x[AW-1:0];
            end
            mmpa_pkg::OP_SCAN_READ: begin
                mem_re = 1'b1;
            end
            mmpa_pkg::OP_PREV_READ: begin
                mem_re    = 1'b1;
                mem_raddr = prev_addr;
            end
            mmpa_pkg::OP_CL_READ: begin
                mem_re    = 1'b1;
                mem_raddr = i_reg[AW-1:0];
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // table memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
            bump_reg <= '0;
            i_reg    <= '0;
            w_reg    <= '0;
        end else begin
            case (op)
                mmpa_pkg::OP_LOAD: begin
                    if (!stat.full) begin
                        used_reg <= used_reg + 1'b1;
                    end
                end
                mmpa_pkg::OP_SCAN_INIT: i_reg <= used_reg;
                mmpa_pkg::OP_SKIP:      i_reg <= e_full;
                mmpa_pkg::OP_PAGE_OK: begin
                    if (kind_reg == mmpa_pkg::KIND_BYTES) begin
                        bump_reg <= found_reg + 32'(bsize_reg);
                    end
                end
                mmpa_pkg::OP_BYTE_FAST: bump_reg <= bump_reg + 32'(bsize_reg);
                mmpa_pkg::OP_CL_INIT: begin
                    i_reg <= '0;
                    w_reg <= '0;
                end
                mmpa_pkg::OP_CL_WRITE: begin
                    i_reg <= i_reg + 1'b1;
                    if (rdata_reg.len != '0) begin
                        w_reg <= w_reg + 1'b1;
                    end
                end
                mmpa_pkg::OP_CL_DONE: used_reg <= w_reg;
                default: begin
                    used_reg <= used_reg;
                end
            endcase
        end
    end

    // request capture, scan payload and staged result
    always_ff @(posedge aclk) begin
        case (op)
            mmpa_pkg::OP_CAPTURE: begin
                kind_reg       <= mmpa_pkg::kind_t'(in_kind);
                type_reg       <= in_type;
                base_reg       <= in_base;
                len_reg        <= in_length;
                pages_reg      <= in_pages;
                bsize_reg      <= (mmpa_pkg::BSZ_W'(in_bytes) + 14'd7) & ~14'd7;
                index_reg      <= in_index;
                res_status_reg <= mmpa_pkg::ST_OK;
                res_addr_reg   <= '0;
                res_entry_reg  <= '0;
            end
            mmpa_pkg::OP_LOAD: begin
                if (stat.full) begin
                    res_status_reg <= mmpa_pkg::ST_FULL;
                end
            end
            mmpa_pkg::OP_RD_DONE:    res_entry_reg  <= rdata_reg;
            mmpa_pkg::OP_RD_BAD:     res_status_reg <= mmpa_pkg::ST_RANGE;
            mmpa_pkg::OP_PAGES_ZERO: res_addr_reg   <= 32'h1000;
            mmpa_pkg::OP_SCAN_INIT: begin
                if (kind_reg == mmpa_pkg::KIND_PAGES) begin
                    size_reg <= {pages_reg, 12'h000};
                end else begin
                    size_reg <= mmpa_pkg::PAGE_SIZE;
                end
            end
            mmpa_pkg::OP_CHECK: begin
                fit_reg  <= fit_c;
                zero_reg <= (rdata_reg.base == '0);
            end
            mmpa_pkg::OP_FIT_WRITE: found_reg    <= rdata_reg.base[31:0];
            mmpa_pkg::OP_PAGE_OK:   res_addr_reg <= found_reg;
            mmpa_pkg::OP_FAIL:      res_status_reg <= mmpa_pkg::ST_NOFIT;
            mmpa_pkg::OP_BYTE_FAST: res_addr_reg <= bump_reg;
            mmpa_pkg::OP_OUT: begin
                o_status_reg <= res_status_reg;
                o_addr_reg   <= res_addr_reg;
                o_count_reg  <= used_o[mmpa_pkg::CNT_W-1:0];
                o_entry_reg  <= res_entry_reg;
            end
            default: begin
                fit_reg <= fit_reg;
            end
        endcase
    end

    assign out_status  = o_status_reg;
    assign out_address = o_addr_reg;
    assign out_count   = o_count_reg;
    assign out_type    = o_entry_reg.rtype;
    assign out_base    = o_entry_reg.base;
    assign out_length  = o_entry_reg.len;

endmodule

@@ rtl/core/mmpa_ctrl.sv @@
module mmpa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  mmpa_pkg::dp_stat_t stat,
    output mmpa_pkg::dp_op_t   op
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RD_WAIT,
        S_SCAN,
        S_CHECK,
        S_DECIDE,
        S_PREV_RD,
        S_PREV_WR,
        S_PAGE_OK,
        S_CL_RD,
        S_CL_WR,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;
    logic   slot_free;

    assign slot_free = !mvalid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = mvalid_reg;

    // next state and command
    always_comb begin
        state_next  = state_reg;
        op          = mmpa_pkg::OP_NONE;
        mvalid_next = mvalid_reg && !m_tready;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op         = mmpa_pkg::OP_CAPTURE;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                state_next = S_DONE;
                case (stat.kind)
                    mmpa_pkg::KIND_LOAD: op = mmpa_pkg::OP_LOAD;
                    mmpa_pkg::KIND_PAGES: begin
                        if (stat.pages_zero) begin
                            op = mmpa_pkg::OP_PAGES_ZERO;
                        end else begin
                            op         = mmpa_pkg::OP_SCAN_INIT;
                            state_next = S_SCAN;
                        end
                    end
                    mmpa_pkg::KIND_BYTES: begin
                        if (stat.need_page) begin
                            op         = mmpa_pkg::OP_SCAN_INIT;
                            state_next = S_SCAN;
                        end else begin
                            op = mmpa_pkg::OP_BYTE_FAST;
                        end
                    end
                    mmpa_pkg::KIND_CLEAN: begin
                        op         = mmpa_pkg::OP_CL_INIT;
                        state_next = S_CL_RD;
                    end
                    mmpa_pkg::KIND_READ: begin
                        if (stat.idx_ok) begin
                            op         = mmpa_pkg::OP_RD_REQ;
                            state_next = S_RD_WAIT;
                        end else begin
                            op = mmpa_pkg::OP_RD_BAD;
                        end
                    end
                    default: op = mmpa_pkg::OP_NONE;
                endcase
            end
            S_RD_WAIT: begin
                op         = mmpa_pkg::OP_RD_DONE;
                state_next = S_DONE;
            end
            // top-down scan, one entry per visit
            S_SCAN: begin
                if (stat.scan_empty) begin
                    op         = mmpa_pkg::OP_FAIL;
                    state_next = S_DONE;
                end else begin
                    op         = mmpa_pkg::OP_SCAN_READ;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                op         = mmpa_pkg::OP_CHECK;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (!stat.fit) begin
                    op         = mmpa_pkg::OP_SKIP;
                    state_next = S_SCAN;
                end else begin
                    op = mmpa_pkg::OP_FIT_WRITE;
                    if (!stat.first) begin
                        state_next = S_PREV_RD;
                    end else if (stat.zero) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_PAGE_OK;
                    end
                end
            end
            // grow the entry below the carved one
            S_PREV_RD: begin
                op         = mmpa_pkg::OP_PREV_READ;
                state_next = S_PREV_WR;
            end
            S_PREV_WR: begin
                op         = mmpa_pkg::OP_PREV_WRITE;
                state_next = stat.zero ? S_SCAN : S_PAGE_OK;
            end
            S_PAGE_OK: begin
                op         = mmpa_pkg::OP_PAGE_OK;
                state_next = S_DONE;
            end
            // compaction sweep
            S_CL_RD: begin
                if (stat.cl_end) begin
                    op         = mmpa_pkg::OP_CL_DONE;
                    state_next = S_DONE;
                end else begin
                    op         = mmpa_pkg::OP_CL_READ;
                    state_next = S_CL_WR;
                end
            end
            S_CL_WR: begin
                op         = mmpa_pkg::OP_CL_WRITE;
                state_next = S_CL_RD;
            end
            S_DONE: begin
                if (slot_free) begin
                    op          = mmpa_pkg::OP_OUT;
                    mvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

@@ rtl/core/memory_map_page_allocator_unit.sv @@
// Memory map page allocator.
// Slave channel: one request beat per command; s_tuser carries the kind
// (load entry, allocate pages, allocate bytes, cleanup, read entry) and
// s_tdata the request fields. Master channel: one result beat per request
// with status, address, entry count and the entry read back.
// One request is worked on at a time. A page scan examines the table
// entries one at a time, top down, and may grow the entry below the
// carved one; cleanup sweeps every entry in turn. The region table is
// accessed one entry at a time, with registered read data.
// The result sits in an output register; a new request is accepted while
// it waits, and a finished request holds in its last state until the
// register is free, so a stalled receiver stalls the next result only.
// Reset empties the table count and the bump pointer; table contents are
// not cleared and no clearing pass is run.
module memory_map_page_allocator_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // region_type, region_base, region_length, page_count, byte_size, read_index
    input  logic [175:0] s_tdata,
    // kind
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, address, count_now, out_type, out_base, out_length
    output logic [175:0] m_tdata
);

    mmpa_pkg::dp_op_t   op;
    mmpa_pkg::dp_stat_t stat;

    logic [1:0]                     out_status;
    logic [mmpa_pkg::OUTA_W-1:0]    out_address;
    logic [mmpa_pkg::CNT_W-1:0]     out_count;
    logic [mmpa_pkg::TYPE_W-1:0]    out_type;
    logic [mmpa_pkg::ADDR_W-1:0]    out_base;
    logic [mmpa_pkg::ADDR_W-1:0]    out_length;

    mmpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .op       (op)
    );

    mmpa_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .op          (op),
        .in_kind     (s_tuser),
        .in_type     (s_tdata[2:0]),
        .in_base     (s_tdata[66:3]),
        .in_length   (s_tdata[130:67]),
        .in_pages    (s_tdata[151:131]),
        .in_bytes    (s_tdata[164:152]),
        .in_index    (s_tdata[170:165]),
        .stat        (stat),
        .out_status  (out_status),
        .out_address (out_address),
        .out_count   (out_count),
        .out_type    (out_type),
        .out_base    (out_base),
        .out_length  (out_length)
    );

    // result packing, lowest field first
    assign m_tdata = {4'b0000, out_length, out_base, out_type, out_count,
                      out_address, out_status};

endmodule
